FILE: hw/rtl/lgpb_pkg.sv
// Shared types, register codes and gamma tables for the LED glow pixel blend unit.
`default_nettype none

package lgpb_pkg;

    localparam int LGPB_TEX_DIM = 1024;
    localparam int COORD_W      = 10;
    localparam int RECT_W       = 11;
    localparam int CHAN_W       = 8;
    localparam int PIXEL_W      = 32;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 11;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LED_ALPHA    = 3'd0,
        REG_LED_RED      = 3'd1,
        REG_LED_GREEN    = 3'd2,
        REG_LED_BLUE     = 3'd3,
        REG_RECT_X_FIRST = 3'd4,
        REG_RECT_X_END   = 3'd5,
        REG_RECT_Y_FIRST = 3'd6,
        REG_RECT_Y_END   = 3'd7
    } lgpb_reg_t;

    // Which gamma curve a color lane applies.
    typedef enum logic [1:0] {
        CHAN_RED   = 2'd0,
        CHAN_GREEN = 2'd1,
        CHAN_BLUE  = 2'd2
    } lgpb_chan_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [PIXEL_W-1:0] old_pixel;
        logic [PIXEL_W-1:0] diffuse_pixel;
    } lgpb_in_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] new_pixel;
        logic               was_painted;
    } lgpb_out_t;

    // Load strobes of the four pipeline registers.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } lgpb_load_t;

    localparam logic [CHAN_W-1:0] GAMMA_RED [256] = '{
        8'd0, 8'd36, 8'd46, 8'd53, 8'd59, 8'd64, 8'd68, 8'd72, 8'd75, 8'd79, 8'd82, 8'd84,
        8'd87, 8'd89, 8'd92, 8'd94, 8'd96, 8'd98, 8'd100, 8'd102, 8'd104, 8'd106, 8'd108,
        8'd109, 8'd111, 8'd113, 8'd114, 8'd116, 8'd117, 8'd119, 8'd120, 8'd121, 8'd123,
        8'd124, 8'd125, 8'd127, 8'd128, 8'd129, 8'd130, 8'd132, 8'd133, 8'd134, 8'd135,
        8'd136, 8'd137, 8'd138, 8'd140, 8'd141, 8'd142, 8'd143, 8'd144, 8'd145, 8'd146,
        8'd147, 8'd148, 8'd149, 8'd150, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155,
        8'd156, 8'd157, 8'd158, 8'd158, 8'd159, 8'd160, 8'd161, 8'd162, 8'd163, 8'd163,
        8'd164, 8'd165, 8'd166, 8'd166, 8'd167, 8'd168, 8'd169, 8'd169, 8'd170, 8'd171,
        8'd172, 8'd172, 8'd173, 8'd174, 8'd175, 8'd175, 8'd176, 8'd177, 8'd177, 8'd178,
        8'd179, 8'd179, 8'd180, 8'd181, 8'd181, 8'd182, 8'd183, 8'd183, 8'd184, 8'd185,
        8'd185, 8'd186, 8'd186, 8'd187, 8'd188, 8'd188, 8'd189, 8'd189, 8'd190, 8'd191,
        8'd191, 8'd192, 8'd192, 8'd193, 8'd194, 8'd194, 8'd195, 8'd195, 8'd196, 8'd197,
        8'd197, 8'd198, 8'd198, 8'd199, 8'd199, 8'd200, 8'd200, 8'd201, 8'd201, 8'd202,
        8'd203, 8'd203, 8'd204, 8'd204, 8'd205, 8'd205, 8'd206, 8'd206, 8'd207, 8'd207,
        8'd208, 8'd208, 8'd209, 8'd209, 8'd210, 8'd210, 8'd211, 8'd211, 8'd212, 8'd212,
        8'd213, 8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216, 8'd216, 8'd217, 8'd217,
        8'd218, 8'd218, 8'd218, 8'd219, 8'd219, 8'd220, 8'd220, 8'd221, 8'd221, 8'd222,
        8'd222, 8'd223, 8'd223, 8'd223, 8'd224, 8'd224, 8'd225, 8'd225, 8'd226, 8'd226,
        8'd227, 8'd227, 8'd227, 8'd228, 8'd228, 8'd229, 8'd229, 8'd230, 8'd230, 8'd230,
        8'd231, 8'd231, 8'd232, 8'd232, 8'd232, 8'd233, 8'd233, 8'd234, 8'd234, 8'd235,
        8'd235, 8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd237, 8'd238, 8'd238, 8'd239,
        8'd239, 8'd239, 8'd240, 8'd240, 8'd240, 8'd241, 8'd241, 8'd242, 8'd242, 8'd242,
        8'd243, 8'd243, 8'd244, 8'd244, 8'd244, 8'd245, 8'd245, 8'd245, 8'd246, 8'd246,
        8'd247, 8'd247, 8'd247, 8'd248, 8'd248, 8'd248, 8'd249, 8'd249, 8'd250, 8'd250,
        8'd250, 8'd251, 8'd251, 8'd251, 8'd252, 8'd252, 8'd252, 8'd253, 8'd253, 8'd253,
        8'd254, 8'd254, 8'd255
    };

    localparam logic [CHAN_W-1:0] GAMMA_GREEN [256] = '{
        8'd0, 8'd48, 8'd59, 8'd67, 8'd73, 8'd78, 8'd82, 8'd86, 8'd90, 8'd93, 8'd96, 8'd99,
        8'd101, 8'd104, 8'd106, 8'd108, 8'd111, 8'd113, 8'd115, 8'd117, 8'd118, 8'd120,
        8'd122, 8'd123, 8'd125, 8'd127, 8'd128, 8'd130, 8'd131, 8'd132, 8'd134, 8'd135,
        8'd136, 8'd138, 8'd139, 8'd140, 8'd141, 8'd142, 8'd144, 8'd145, 8'd146, 8'd147,
        8'd148, 8'd149, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155, 8'd156, 8'd157,
        8'd158, 8'd159, 8'd160, 8'd160, 8'd161, 8'd162, 8'd163, 8'd164, 8'd165, 8'd166,
        8'd166, 8'd167, 8'd168, 8'd169, 8'd169, 8'd170, 8'd171, 8'd172, 8'd173, 8'd173,
        8'd174, 8'd175, 8'd175, 8'd176, 8'd177, 8'd178, 8'd178, 8'd179, 8'd180, 8'd180,
        8'd181, 8'd182, 8'd182, 8'd183, 8'd184, 8'd184, 8'd185, 8'd185, 8'd186, 8'd187,
        8'd187, 8'd188, 8'd189, 8'd189, 8'd190, 8'd190, 8'd191, 8'd191, 8'd192, 8'd193,
        8'd193, 8'd194, 8'd194, 8'd195, 8'd195, 8'd196, 8'd197, 8'd197, 8'd198, 8'd198,
        8'd199, 8'd199, 8'd200, 8'd200, 8'd201, 8'd201, 8'd202, 8'd202, 8'd203, 8'd203,
        8'd204, 8'd204, 8'd205, 8'd205, 8'd206, 8'd206, 8'd207, 8'd207, 8'd208, 8'd208,
        8'd209, 8'd209, 8'd210, 8'd210, 8'd211, 8'd211, 8'd212, 8'd212, 8'd213, 8'd213,
        8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216, 8'd216, 8'd217, 8'd217, 8'd217,
        8'd218, 8'd218, 8'd219, 8'd219, 8'd220, 8'd220, 8'd220, 8'd221, 8'd221, 8'd222,
        8'd222, 8'd222, 8'd223, 8'd223, 8'd224, 8'd224, 8'd224, 8'd225, 8'd225, 8'd226,
        8'd226, 8'd226, 8'd227, 8'd227, 8'd228, 8'd228, 8'd228, 8'd229, 8'd229, 8'd230,
        8'd230, 8'd230, 8'd231, 8'd231, 8'd231, 8'd232, 8'd232, 8'd233, 8'd233, 8'd233,
        8'd234, 8'd234, 8'd234, 8'd235, 8'd235, 8'd236, 8'd236, 8'd236, 8'd237, 8'd237,
        8'd237, 8'd238, 8'd238, 8'd238, 8'd239, 8'd239, 8'd239, 8'd240, 8'd240, 8'd240,
        8'd241, 8'd241, 8'd241, 8'd242, 8'd242, 8'd242, 8'd243, 8'd243, 8'd243, 8'd244,
        8'd244, 8'd244, 8'd245, 8'd245, 8'd245, 8'd246, 8'd246, 8'd246, 8'd247, 8'd247,
        8'd247, 8'd248, 8'd248, 8'd248, 8'd249, 8'd249, 8'd249, 8'd250, 8'd250, 8'd250,
        8'd251, 8'd251, 8'd251, 8'd251, 8'd252, 8'd252, 8'd252, 8'd253, 8'd253, 8'd253,
        8'd254, 8'd254, 8'd254, 8'd255
    };

    localparam logic [CHAN_W-1:0] GAMMA_BLUE [256] = '{
        8'd0, 8'd27, 8'd36, 8'd43, 8'd48, 8'd52, 8'd56, 8'd60, 8'd63, 8'd66, 8'd69, 8'd72,
        8'd75, 8'd77, 8'd79, 8'd82, 8'd84, 8'd86, 8'd88, 8'd90, 8'd92, 8'd93, 8'd95, 8'd97,
        8'd99, 8'd100, 8'd102, 8'd103, 8'd105, 8'd106, 8'd108, 8'd109, 8'd111, 8'd112,
        8'd113, 8'd115, 8'd116, 8'd117, 8'd119, 8'd120, 8'd121, 8'd122, 8'd123, 8'd125,
        8'd126, 8'd127, 8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd136,
        8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd141, 8'd142, 8'd143, 8'd144, 8'd145,
        8'd146, 8'd147, 8'd148, 8'd149, 8'd150, 8'd151, 8'd152, 8'd152, 8'd153, 8'd154,
        8'd155, 8'd156, 8'd157, 8'd157, 8'd158, 8'd159, 8'd160, 8'd161, 8'd161, 8'd162,
        8'd163, 8'd164, 8'd165, 8'd165, 8'd166, 8'd167, 8'd168, 8'd168, 8'd169, 8'd170,
        8'd171, 8'd171, 8'd172, 8'd173, 8'd173, 8'd174, 8'd175, 8'd176, 8'd176, 8'd177,
        8'd178, 8'd178, 8'd179, 8'd180, 8'd180, 8'd181, 8'd182, 8'd182, 8'd183, 8'd184,
        8'd184, 8'd185, 8'd186, 8'd186, 8'd187, 8'd187, 8'd188, 8'd189, 8'd189, 8'd190,
        8'd191, 8'd191, 8'd192, 8'd192, 8'd193, 8'd194, 8'd194, 8'd195, 8'd195, 8'd196,
        8'd197, 8'd197, 8'd198, 8'd198, 8'd199, 8'd200, 8'd200, 8'd201, 8'd201, 8'd202,
        8'd202, 8'd203, 8'd204, 8'd204, 8'd205, 8'd205, 8'd206, 8'd206, 8'd207, 8'd207,
        8'd208, 8'd208, 8'd209, 8'd210, 8'd210, 8'd211, 8'd211, 8'd212, 8'd212, 8'd213,
        8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216, 8'd216, 8'd217, 8'd217, 8'd218,
        8'd218, 8'd219, 8'd219, 8'd220, 8'd220, 8'd221, 8'd221, 8'd222, 8'd222, 8'd223,
        8'd223, 8'd224, 8'd224, 8'd225, 8'd225, 8'd226, 8'd226, 8'd227, 8'd227, 8'd228,
        8'd228, 8'd229, 8'd229, 8'd229, 8'd230, 8'd230, 8'd231, 8'd231, 8'd232, 8'd232,
        8'd233, 8'd233, 8'd234, 8'd234, 8'd235, 8'd235, 8'd235, 8'd236, 8'd236, 8'd237,
        8'd237, 8'd238, 8'd238, 8'd239, 8'd239, 8'd239, 8'd240, 8'd240, 8'd241, 8'd241,
        8'd242, 8'd242, 8'd242, 8'd243, 8'd243, 8'd244, 8'd244, 8'd245, 8'd245, 8'd245,
        8'd246, 8'd246, 8'd247, 8'd247, 8'd248, 8'd248, 8'd248, 8'd249, 8'd249, 8'd250,
        8'd250, 8'd250, 8'd251, 8'd251, 8'd252, 8'd252, 8'd252, 8'd253, 8'd253, 8'd254,
        8'd254, 8'd255
    };

endpackage

`default_nettype wire

FILE: hw/rtl/led_glow_pixel_blend_unit.sv
// Top level of the LED glow pixel blend unit: config registers and four-stage pixel pipeline.
`default_nettype none

// The unit paints an LED glow into a texture one pixel at a time. Each input
// transfer carries a pixel position, the old ARGB pixel and the ARGB diffusion
// map pixel; each input transfer yields exactly one output transfer, in order.
// A pixel inside the rectangle [rect_x_first, rect_x_end) x [rect_y_first,
// rect_y_end), with both coordinates also below TEX_DIM, has the LED color
// scaled by the diffusion channels, red, green and blue shaped by fixed gamma
// tables, and the result blended over the old pixel with alpha forced to 255;
// was_painted is then set. Any other pixel comes out unchanged with
// was_painted clear. The pipeline has four register stages (scale multiply,
// gamma lookup, blend multiply, blend sum). Each pixel moves through them in
// that order and is offered on the output from the stage 4 register, and a
// new pixel is taken every cycle while the output side does not stall. The
// last stage is the output register; when it is stalled, earlier stages keep
// filling bubbles before in_stall rises.
// Configuration registers are written through cfg_write/cfg_index/cfg_data,
// take effect at once and must only change while the pipeline is empty.

module led_glow_pixel_blend_unit
    import lgpb_pkg::*;
#(
    parameter int TEX_DIM = LGPB_TEX_DIM
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire lgpb_in_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output lgpb_out_t                   out_data
);

    // Compare width covers both the rectangle bounds and TEX_DIM itself.
    localparam int DIM_W  = $clog2(TEX_DIM + 1);
    localparam int CMP_W  = (DIM_W > RECT_W) ? DIM_W : RECT_W;
    localparam int PROD_W = 2 * CHAN_W;
    localparam logic [CMP_W-1:0] DIM_LIMIT = CMP_W'(TEX_DIM);
    localparam logic [CHAN_W-1:0] FULL_ALPHA = '1;

    // Configuration registers.
    logic [CHAN_W-1:0] led_alpha_reg;
    logic [CHAN_W-1:0] led_red_reg;
    logic [CHAN_W-1:0] led_green_reg;
    logic [CHAN_W-1:0] led_blue_reg;
    logic [RECT_W-1:0] rect_x_first_reg;
    logic [RECT_W-1:0] rect_x_end_reg;
    logic [RECT_W-1:0] rect_y_first_reg;
    logic [RECT_W-1:0] rect_y_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_alpha_reg    <= '0;
            led_red_reg      <= '0;
            led_green_reg    <= '0;
            led_blue_reg     <= '0;
            rect_x_first_reg <= '0;
            rect_x_end_reg   <= '0;
            rect_y_first_reg <= '0;
            rect_y_end_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (lgpb_reg_t'(cfg_index))
                REG_LED_ALPHA:    led_alpha_reg    <= cfg_data[CHAN_W-1:0];
                REG_LED_RED:      led_red_reg      <= cfg_data[CHAN_W-1:0];
                REG_LED_GREEN:    led_green_reg    <= cfg_data[CHAN_W-1:0];
                REG_LED_BLUE:     led_blue_reg     <= cfg_data[CHAN_W-1:0];
                REG_RECT_X_FIRST: rect_x_first_reg <= cfg_data[RECT_W-1:0];
                REG_RECT_X_END:   rect_x_end_reg   <= cfg_data[RECT_W-1:0];
                REG_RECT_Y_FIRST: rect_y_first_reg <= cfg_data[RECT_W-1:0];
                REG_RECT_Y_END:   rect_y_end_reg   <= cfg_data[RECT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Pipeline flow control. A stage may load when it is empty or when the
    // stage after it is moving; the output side closes the chain.
    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    logic       rdy1, rdy2, rdy3, rdy4;
    lgpb_load_t load;

    assign rdy4 = !v4_reg || !out_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign load.s1 = rdy1;
    assign load.s2 = rdy2;
    assign load.s3 = rdy3;
    assign load.s4 = rdy4;

    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: rectangle test and the alpha scale product.
    logic [CMP_W-1:0]  px_ext;
    logic [CMP_W-1:0]  py_ext;
    logic              pixel_in_rect;
    logic [PROD_W-1:0] alpha_prod;

    assign px_ext = CMP_W'(in_data.pixel_x);
    assign py_ext = CMP_W'(in_data.pixel_y);

    assign pixel_in_rect = (px_ext >= CMP_W'(rect_x_first_reg))
                        && (px_ext < CMP_W'(rect_x_end_reg))
                        && (py_ext >= CMP_W'(rect_y_first_reg))
                        && (py_ext < CMP_W'(rect_y_end_reg))
                        && (px_ext < DIM_LIMIT) && (py_ext < DIM_LIMIT);

    assign alpha_prod = PROD_W'(led_alpha_reg) * PROD_W'(in_data.diffuse_pixel[31:24]);

    logic               inside_s1_reg, inside_s2_reg, inside_s3_reg;
    logic [PIXEL_W-1:0] old_s1_reg, old_s2_reg, old_s3_reg;
    logic [CHAN_W-1:0]  alpha_s1_reg, alpha_s2_reg;
    logic [CHAN_W-1:0]  inv_alpha_s2_reg;
    lgpb_out_t          out_reg;

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            inside_s1_reg <= pixel_in_rect;
            old_s1_reg    <= in_data.old_pixel;
            alpha_s1_reg  <= alpha_prod[PROD_W-1:CHAN_W];
        end
        if (load.s2)
        begin
            inside_s2_reg    <= inside_s1_reg;
            old_s2_reg       <= old_s1_reg;
            alpha_s2_reg     <= alpha_s1_reg;
            inv_alpha_s2_reg <= FULL_ALPHA - alpha_s1_reg;
        end
        if (load.s3)
        begin
            inside_s3_reg <= inside_s2_reg;
            old_s3_reg    <= old_s2_reg;
        end
    end

    // Color lanes, stages 1 through 4.
    logic [CHAN_W-1:0] red_blend, green_blend, blue_blend;

    lgpb_color_lane #(.CHAN(CHAN_RED)) u_lane_red (
        .clk          (clk),
        .load         (load),
        .led_level    (led_red_reg),
        .diffuse_level(in_data.diffuse_pixel[23:16]),
        .old_level    (in_data.old_pixel[23:16]),
        .alpha_s2     (alpha_s2_reg),
        .inv_alpha_s2 (inv_alpha_s2_reg),
        .blended      (red_blend)
    );

    lgpb_color_lane #(.CHAN(CHAN_GREEN)) u_lane_green (
        .clk          (clk),
        .load         (load),
        .led_level    (led_green_reg),
        .diffuse_level(in_data.diffuse_pixel[15:8]),
        .old_level    (in_data.old_pixel[15:8]),
        .alpha_s2     (alpha_s2_reg),
        .inv_alpha_s2 (inv_alpha_s2_reg),
        .blended      (green_blend)
    );

    lgpb_color_lane #(.CHAN(CHAN_BLUE)) u_lane_blue (
        .clk          (clk),
        .load         (load),
        .led_level    (led_blue_reg),
        .diffuse_level(in_data.diffuse_pixel[7:0]),
        .old_level    (in_data.old_pixel[7:0]),
        .alpha_s2     (alpha_s2_reg),
        .inv_alpha_s2 (inv_alpha_s2_reg),
        .blended      (blue_blend)
    );

    // Stage 4 is the output register. The lanes register their blend sums in
    // the same stage, so the painted/unpainted choice is made on the way out
    // from a registered flag and the pass-through copy of the old pixel.
    logic               inside_s4_reg;
    logic [PIXEL_W-1:0] old_s4_reg;

    always_ff @(posedge clk)
    begin
        if (load.s4)
        begin
            inside_s4_reg <= inside_s3_reg;
            old_s4_reg    <= old_s3_reg;
        end
    end

    always_comb
    begin
        out_reg.was_painted = inside_s4_reg;
        if (inside_s4_reg)
        begin
            out_reg.new_pixel = {FULL_ALPHA, red_blend, green_blend, blue_blend};
        end
        else
        begin
            out_reg.new_pixel = old_s4_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lgpb_color_lane.sv
// One color channel of the blend pipeline: scale, gamma lookup and alpha blend.
`default_nettype none

module lgpb_color_lane
    import lgpb_pkg::*;
#(
    parameter lgpb_chan_t CHAN = CHAN_RED
)
(
    input  wire logic              clk,
    input  wire lgpb_load_t        load,
    input  wire logic [CHAN_W-1:0] led_level,
    input  wire logic [CHAN_W-1:0] diffuse_level,
    input  wire logic [CHAN_W-1:0] old_level,
    input  wire logic [CHAN_W-1:0] alpha_s2,
    input  wire logic [CHAN_W-1:0] inv_alpha_s2,
    output logic      [CHAN_W-1:0] blended
);

    localparam int PROD_W = 2 * CHAN_W;

    logic [CHAN_W-1:0] scaled_reg;
    logic [CHAN_W-1:0] old_s1_reg;
    logic [CHAN_W-1:0] gamma_reg;
    logic [CHAN_W-1:0] old_s2_reg;
    logic [PROD_W-1:0] dst_prod_reg;
    logic [PROD_W-1:0] src_prod_reg;
    logic [CHAN_W-1:0] blend_reg;

    logic [PROD_W-1:0] scale_prod;
    logic [CHAN_W-1:0] gamma_next;
    logic [PROD_W-1:0] blend_sum;

    assign scale_prod = PROD_W'(led_level) * PROD_W'(diffuse_level);

    always_comb
    begin
        case (CHAN)
            CHAN_RED:   gamma_next = GAMMA_RED[scaled_reg];
            CHAN_GREEN: gamma_next = GAMMA_GREEN[scaled_reg];
            default:    gamma_next = GAMMA_BLUE[scaled_reg];
        endcase
    end

    // Both products stay at most 255*255 in sum, so the sum fits the product width.
    assign blend_sum = dst_prod_reg + src_prod_reg;

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            scaled_reg <= scale_prod[PROD_W-1:CHAN_W];
            old_s1_reg <= old_level;
        end
        if (load.s2)
        begin
            gamma_reg  <= gamma_next;
            old_s2_reg <= old_s1_reg;
        end
        if (load.s3)
        begin
            dst_prod_reg <= PROD_W'(old_s2_reg) * PROD_W'(inv_alpha_s2);
            src_prod_reg <= PROD_W'(gamma_reg) * PROD_W'(alpha_s2);
        end
        if (load.s4)
        begin
            blend_reg <= blend_sum[PROD_W-1:CHAN_W];
        end
    end

    assign blended = blend_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lgpb_checker.sv
// Port-level checks of the LED glow pixel blend unit and their bind to the top level.
`default_nettype none

module lgpb_checker
    import lgpb_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_stall,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire lgpb_out_t out_data
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transfer withdrawn while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("output payload changed while stalled");

    // With an empty output register the whole pipeline can move.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output register is empty");

    // A free output side sustains one transfer per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output side is free");

    // Painted pixels always leave with full alpha.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.was_painted |-> out_data.new_pixel[31:24] == 8'hff)
        else $error("painted pixel without full alpha");

endmodule

bind led_glow_pixel_blend_unit lgpb_checker u_lgpb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);

`default_nettype wire
